/* rtl/lfu_pkg.sv */
// lfu_pkg: sizes, entry and victim records, and the store command word for the
// LFU cache table. No dependencies; every other file imports it.
package lfu_pkg;

    localparam int CAPACITY    = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int DATA_W      = 32;
    localparam int LIMIT_W     = 5;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W       = $clog2(CAPACITY + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [DATA_W-1:0]      data_t;
    typedef logic [OCC_W-1:0]       occ_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BUMP,
        OP_EVICT,
        OP_INSERT
    } op_kind_t;

    // One table entry as seen on the scan read port.
    typedef struct packed {
        logic   valid;
        data_t  key;
        data_t  value;
        count_t count;
        idx_t   rank;
    } entry_t;

    // Running best candidate of a victim search.
    typedef struct packed {
        logic   have;
        count_t count;
        idx_t   rank;
    } victim_t;

    // Compare unit result.
    typedef struct packed {
        logic key_hit;
        logic better;
    } cmp_res_t;

    // Update command from the sequencer to the entry store.
    typedef struct packed {
        op_kind_t kind;
        idx_t     idx;
        idx_t     ref_rank;
        idx_t     new_rank;
        logic     wr_value;
        data_t    key;
        data_t    value;
    } store_op_t;

endpackage

/* rtl/lfu_ifs.sv */
// lfu_ifs: valid/ready channel interfaces for requests, responses and the
// capacity register write. Depends on lfu_pkg.
interface lfu_req_if
    import lfu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lfu_rsp_if
    import lfu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;

    modport source (output valid, output hit, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    output ready);
endinterface

interface lfu_cfg_if
    import lfu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

/* rtl/lfu_cmp_unit.sv */
// lfu_cmp_unit: shared compare unit, key match and LFU/LRU ordering of one
// entry against the running victim. Depends on lfu_pkg.
module lfu_cmp_unit
    import lfu_pkg::*;
(
    input  entry_t   ent,
    input  data_t    probe_key,
    input  victim_t  best,
    output cmp_res_t res
);

    logic lower_count;
    logic tie_older;

    assign lower_count = ent.count < best.count;
    assign tie_older   = (ent.count == best.count) && (ent.rank < best.rank);

    assign res.key_hit = ent.valid && (ent.key == probe_key);
    assign res.better  = ent.valid && (!best.have || lower_count || tie_older);

endmodule

/* rtl/lfu_entry_store.sv */
// lfu_entry_store: table of keys, values, use counts, recency ranks and valid
// bits; one scan read port and one update command a cycle. Depends on lfu_pkg.
module lfu_entry_store
    import lfu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  idx_t      rd_idx,
    output entry_t    rd_entry,
    input  store_op_t op
);

    logic   [CAPACITY-1:0] valid_reg;
    data_t                 key_reg   [CAPACITY];
    data_t                 value_reg [CAPACITY];
    count_t                count_reg [CAPACITY];
    idx_t                  rank_reg  [CAPACITY];

    assign rd_entry.valid = valid_reg[rd_idx];
    assign rd_entry.key   = key_reg[rd_idx];
    assign rd_entry.value = value_reg[rd_idx];
    assign rd_entry.count = count_reg[rd_idx];
    assign rd_entry.rank  = rank_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            unique case (op.kind)
                OP_EVICT:  valid_reg[op.idx] <= 1'b0;
                OP_INSERT: valid_reg[op.idx] <= 1'b1;
                default:   ;
            endcase
        end
    end

    // Close the rank gap left by a bumped or evicted entry, then write it.
    always_ff @(posedge clk)
    begin
        if (op.kind == OP_BUMP || op.kind == OP_EVICT)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (valid_reg[i] && rank_reg[i] > op.ref_rank)
                    rank_reg[i] <= rank_reg[i] - idx_t'(1);
            end
        end
        unique case (op.kind)
            OP_BUMP:
            begin
                rank_reg[op.idx] <= op.new_rank;
                if (count_reg[op.idx] != '1)
                    count_reg[op.idx] <= count_reg[op.idx] + count_t'(1);
                if (op.wr_value)
                    value_reg[op.idx] <= op.value;
            end
            OP_INSERT:
            begin
                key_reg[op.idx]   <= op.key;
                value_reg[op.idx] <= op.value;
                count_reg[op.idx] <= count_t'(1);
                rank_reg[op.idx]  <= op.new_rank;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/lfu_cache_table_unit.sv */
// lfu_cache_table_unit: top level of the LFU cache table, scan sequencer around
// the entry store and the shared compare unit. Depends on lfu_pkg, lfu_ifs.
//
//  channel | dir | word                              | taken when
//  --------+-----+-----------------------------------+------------------------
//  req     | in  | cmd, key, value                   | valid & ready (idle)
//  rsp     | out | hit, read_value, evicted          | valid & ready
//  cfg     | in  | capacity_limit                    | valid (ready held high)
//
// A get, a put hit or a dropped put passes through accept, a scan of every entry
// and an update before the response word is shown; a put of a new key adds an
// insert step. Each eviction a put miss needs adds a victim scan of every entry
// and a rank fixup. The scans read one entry a cycle through the compare unit.
// Reset clears the valid bits at once; no clearing pass.
// req is not ready from accept until the response word has been taken.
module lfu_cache_table_unit
    import lfu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    lfu_req_if.sink        req,
    lfu_rsp_if.source      rsp,
    lfu_cfg_if.sink        cfg
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_VSCAN  = 7'b0001000,
        S_EVICT  = 7'b0010000,
        S_INSERT = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t             state_reg,     state_next;
    idx_t               idx_reg,       idx_next;
    logic               cmd_reg,       cmd_next;
    data_t              key_reg,       key_next;
    data_t              value_reg,     value_next;
    logic [LIMIT_W-1:0] cap_limit_reg, cap_limit_next;
    occ_t               limit_reg,     limit_next;
    occ_t               occ_reg,       occ_next;
    logic               found_reg,     found_next;
    idx_t               fidx_reg,      fidx_next;
    data_t              fval_reg,      fval_next;
    idx_t               frank_reg,     frank_next;
    logic               free_have_reg, free_have_next;
    idx_t               free_idx_reg,  free_idx_next;
    victim_t            victim_reg,    victim_next;
    idx_t               vidx_reg,      vidx_next;
    logic               hit_reg,       hit_next;
    data_t              rval_reg,      rval_next;
    logic               evicted_reg,   evicted_next;

    entry_t    entry;
    cmp_res_t  cmp;
    store_op_t op;
    logic      last_idx;
    occ_t      occ_dec;
    occ_t      limit_eff;

    lfu_entry_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_entry (entry),
        .op       (op)
    );

    lfu_cmp_unit u_cmp (
        .ent       (entry),
        .probe_key (key_reg),
        .best      (victim_reg),
        .res       (cmp)
    );

    assign last_idx = (idx_reg == idx_t'(CAPACITY - 1));
    assign occ_dec  = occ_reg - occ_t'(1);

    // Clamp the register to the table size when the word is taken.
    assign limit_eff = (32'(cap_limit_reg) > 32'(CAPACITY)) ? occ_t'(CAPACITY)
                                                            : occ_t'(cap_limit_reg);

    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = (state_reg == S_RESP);
    assign rsp.hit        = hit_reg;
    assign rsp.read_value = rval_reg;
    assign rsp.evicted    = evicted_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        cap_limit_next = cap_limit_reg;
        limit_next     = limit_reg;
        occ_next       = occ_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        fval_next      = fval_reg;
        frank_next     = frank_reg;
        free_have_next = free_have_reg;
        free_idx_next  = free_idx_reg;
        victim_next    = victim_reg;
        vidx_next      = vidx_reg;
        hit_next       = hit_reg;
        rval_next      = rval_reg;
        evicted_next   = evicted_reg;

        op          = '0;
        op.kind     = OP_NONE;
        op.key      = key_reg;
        op.value    = value_reg;

        if (cfg.valid)
            cap_limit_next = cfg.capacity_limit;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = req.cmd;
                    key_next       = req.key;
                    value_next     = req.value;
                    limit_next     = limit_eff;
                    idx_next       = '0;
                    occ_next       = '0;
                    found_next     = 1'b0;
                    free_have_next = 1'b0;
                    hit_next       = 1'b0;
                    rval_next      = '0;
                    evicted_next   = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            // Count occupancy, find the key and the lowest free slot.
            S_SCAN:
            begin
                if (entry.valid)
                    occ_next = occ_reg + occ_t'(1);
                else if (!free_have_reg)
                begin
                    free_have_next = 1'b1;
                    free_idx_next  = idx_reg;
                end
                if (cmp.key_hit && !found_reg)
                begin
                    found_next = 1'b1;
                    fidx_next  = idx_reg;
                    fval_next  = entry.value;
                    frank_next = entry.rank;
                end
                idx_next = idx_reg + idx_t'(1);
                if (last_idx)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                if (cmd_reg == CMD_GET)
                begin
                    if (found_reg)
                    begin
                        op.kind     = OP_BUMP;
                        op.idx      = fidx_reg;
                        op.ref_rank = frank_reg;
                        op.new_rank = idx_t'(occ_dec);
                        hit_next    = 1'b1;
                        rval_next   = fval_reg;
                    end
                end
                else if (limit_reg == '0)
                begin
                    // Stores disabled: drop the put.
                end
                else if (found_reg)
                begin
                    op.kind     = OP_BUMP;
                    op.idx      = fidx_reg;
                    op.ref_rank = frank_reg;
                    op.new_rank = idx_t'(occ_dec);
                    op.wr_value = 1'b1;
                    hit_next    = 1'b1;
                end
                else if (occ_reg >= limit_reg)
                begin
                    idx_next    = '0;
                    victim_next = '0;
                    state_next  = S_VSCAN;
                end
                else
                    state_next = S_INSERT;
            end
            // Search the lowest count, oldest on ties.
            S_VSCAN:
            begin
                if (cmp.better)
                begin
                    victim_next.have  = 1'b1;
                    victim_next.count = entry.count;
                    victim_next.rank  = entry.rank;
                    vidx_next         = idx_reg;
                end
                idx_next = idx_reg + idx_t'(1);
                if (last_idx)
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                state_next = S_INSERT;
                if (victim_reg.have)
                begin
                    op.kind      = OP_EVICT;
                    op.idx       = vidx_reg;
                    op.ref_rank  = victim_reg.rank;
                    occ_next     = occ_dec;
                    evicted_next = 1'b1;
                    if (!free_have_reg || vidx_reg < free_idx_reg)
                    begin
                        free_have_next = 1'b1;
                        free_idx_next  = vidx_reg;
                    end
                    // Keep evicting while the table is still at or above its limit.
                    if (occ_dec >= limit_reg)
                    begin
                        idx_next    = '0;
                        victim_next = '0;
                        state_next  = S_VSCAN;
                    end
                end
            end
            S_INSERT:
            begin
                if (free_have_reg)
                begin
                    op.kind     = OP_INSERT;
                    op.idx      = free_idx_reg;
                    op.new_rank = idx_t'(occ_reg);
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cmd_reg       <= 1'b0;
            key_reg       <= '0;
            value_reg     <= '0;
            cap_limit_reg <= LIMIT_RESET;
            limit_reg     <= '0;
            occ_reg       <= '0;
            found_reg     <= 1'b0;
            fidx_reg      <= '0;
            fval_reg      <= '0;
            frank_reg     <= '0;
            free_have_reg <= 1'b0;
            free_idx_reg  <= '0;
            victim_reg    <= '0;
            vidx_reg      <= '0;
            hit_reg       <= 1'b0;
            rval_reg      <= '0;
            evicted_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmd_reg       <= cmd_next;
            key_reg       <= key_next;
            value_reg     <= value_next;
            cap_limit_reg <= cap_limit_next;
            limit_reg     <= limit_next;
            occ_reg       <= occ_next;
            found_reg     <= found_next;
            fidx_reg      <= fidx_next;
            fval_reg      <= fval_next;
            frank_reg     <= frank_next;
            free_have_reg <= free_have_next;
            free_idx_reg  <= free_idx_next;
            victim_reg    <= victim_next;
            vidx_reg      <= vidx_next;
            hit_reg       <= hit_next;
            rval_reg      <= rval_next;
            evicted_reg   <= evicted_next;
        end
    end

endmodule

/* bench/lfu_cache_checker.sv */
// lfu_cache_checker: watches the request, response and capacity channels of the
// LFU cache table, predicts each response word and compares it field by field.
// Depends on lfu_pkg and the channel interfaces of lfu_ifs.
`timescale 1ns / 100ps

module lfu_cache_checker
    import lfu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lfu_req_if   req,
    lfu_rsp_if   rsp,
    lfu_cfg_if   cfg,
    input  logic drain_done,
    output int   failures,
    output int   waiting,
    output int   served,
    output int   hits,
    output int   evictions
);

    typedef struct packed {
        logic  hit;
        data_t read_value;
        logic  evicted;
    } answer_t;

    answer_t answers_due[$];

    logic               slot_valid [CAPACITY];
    data_t              slot_key   [CAPACITY];
    data_t              slot_value [CAPACITY];
    count_t             slot_uses  [CAPACITY];
    int                 slot_age   [CAPACITY];   // higher is more recent
    logic [LIMIT_W-1:0] limit_reg;
    logic               end_checked;

    function automatic int occupied();
        int n;
        n = 0;
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i])
                n++;
        return n;
    endfunction

    // Move entry e to the newest age and close the gap it leaves.
    function automatic void make_newest(int e);
        int r;
        int n;
        r = slot_age[e];
        n = occupied();
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_age[i] > r)
                slot_age[i]--;
        slot_age[e] = n - 1;
    endfunction

    function automatic void use_entry(int e);
        if (slot_uses[e] != '1)
            slot_uses[e]++;
        make_newest(e);
    endfunction

    // Drop the entry with the fewest uses, the oldest one on a tie.
    function automatic void evict_coldest();
        int v;
        v = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i])
                if (v < 0 || slot_uses[i] < slot_uses[v] ||
                    (slot_uses[i] == slot_uses[v] && slot_age[i] < slot_age[v]))
                    v = i;
        if (v < 0)
            return;
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_age[i] > slot_age[v])
                slot_age[i]--;
        slot_valid[v] = 1'b0;
    endfunction

    function automatic answer_t serve(logic op, data_t k, data_t v);
        answer_t a;
        int      lim;
        int      found;
        int      free;
        a     = '0;
        lim   = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
        found = -1;
        free  = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == k)
                found = i;
        if (op == CMD_GET)
        begin
            if (found >= 0)
            begin
                a.hit        = 1'b1;
                a.read_value = slot_value[found];
                use_entry(found);
            end
            return a;
        end
        // stores disabled: drop the put, even on a present key
        if (lim == 0)
            return a;
        if (found >= 0)
        begin
            a.hit             = 1'b1;
            slot_value[found] = v;
            use_entry(found);
            return a;
        end
        // evict until there is room, several times if the limit was lowered
        while (occupied() >= lim)
        begin
            evict_coldest();
            a.evicted = 1'b1;
        end
        for (int i = 0; i < CAPACITY; i++)
            if (free < 0 && !slot_valid[i])
                free = i;
        if (free < 0)
            return a;
        slot_age[free]   = occupied();
        slot_valid[free] = 1'b1;
        slot_key[free]   = k;
        slot_value[free] = v;
        slot_uses[free]  = count_t'(1);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t due;
        if (!rst_n)
        begin
            limit_reg   = LIMIT_RESET;
            end_checked = 1'b0;
            answers_due.delete();
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_uses[i]  = '0;
                slot_age[i]   = 0;
            end
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("response word with nothing outstanding: hit %0b value %h evicted %0b",
                           rsp.hit, rsp.read_value, rsp.evicted);
                    failures++;
                end
                else
                begin
                    due = answers_due[0];
                    answers_due.delete(0);
                    served++;
                    if (due.hit)
                        hits++;
                    if (due.evicted)
                        evictions++;
                    if (rsp.hit !== due.hit)
                    begin
                        $error("hit mismatch: expected %0b, got %0b", due.hit, rsp.hit);
                        failures++;
                    end
                    if (data_t'(rsp.read_value) !== due.read_value)
                    begin
                        $error("read_value mismatch: expected %h, got %h",
                               due.read_value, rsp.read_value);
                        failures++;
                    end
                    if (rsp.evicted !== due.evicted)
                    begin
                        $error("evicted mismatch: expected %0b, got %0b",
                               due.evicted, rsp.evicted);
                        failures++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                due = serve(req.cmd, data_t'(req.key), data_t'(req.value));
                answers_due.insert(answers_due.size(), due);
            end
            if (cfg.valid && cfg.ready)
                limit_reg = cfg.capacity_limit;
            if (drain_done && !end_checked)
            begin
                end_checked = 1'b1;
                if (answers_due.size() != 0)
                begin
                    $error("%0d response words never arrived", answers_due.size());
                    failures++;
                end
            end
        end
        waiting = answers_due.size();
    end

endmodule

/* bench/tb.sv */
// tb: stimulus and verdict for lfu_cache_table_unit; directed words, then random
// phases over several capacity limits. Depends on lfu_pkg, lfu_ifs, lfu_cache_checker.
`timescale 1ns / 100ps

module tb
    import lfu_pkg::*;
();

    localparam int RANDOM_WORDS  = 1250;
    localparam int PHASES        = 8;
    localparam int POOL_SIZE     = 24;
    // Settle time, sized from a put miss that evicts once.
    localparam int SETTLE_CYCLES = 2 * (CAPACITY + 2);

    // Limits of the random phases, element 0 first: above the table size,
    // small, one, disabled, full size, two in between, and again one above the table size.
    localparam logic [PHASES-1:0][LIMIT_W-1:0] PHASE_LIMIT =
        {5'd17, 5'd9, 5'd2, 5'd16, 5'd0, 5'd1, 5'd5, 5'd31};

    logic  clk = 1'b0;
    logic  rst_n;
    logic  drain_done;
    int    src_idle_pct;
    int    dst_idle_pct;
    int    failures;
    int    waiting;
    int    served;
    int    hits;
    int    evictions;
    int    settings_used;
    data_t key_pool [POOL_SIZE];

    lfu_req_if req();
    lfu_rsp_if rsp();
    lfu_cfg_if cfg();

    lfu_cache_table_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    lfu_cache_checker i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .drain_done (drain_done),
        .failures   (failures),
        .waiting    (waiting),
        .served     (served),
        .hits       (hits),
        .evictions  (evictions)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: drop ready at random, re-decided at every falling edge.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready = ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Send one request word. Called at a falling edge; returns at the falling
    // edge after the word was taken, with valid still high.
    task automatic send_word(input logic op, input data_t k, input data_t v);
        // idle for a random number of cycles, with junk on the payload
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid = 1'b0;
            req.cmd   = 1'($urandom_range(1));
            req.key   = $urandom();
            req.value = $urandom();
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.cmd   = op;
        req.key   = k;
        req.value = v;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    // Drop valid, wait until every response word is in, then let the block
    // settle so that a register write finds it idle.
    task automatic settle();
        req.valid = 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        cfg.capacity_limit = lim;
        cfg.valid          = 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int eff;
        int span;
        int base;
        logic op;
        data_t k;

        // Hold every input at a known value from time zero.
        rst_n              = 1'b0;
        drain_done         = 1'b0;
        req.valid          = 1'b0;
        req.cmd            = CMD_GET;
        req.key            = '0;
        req.value          = '0;
        cfg.valid          = 1'b0;
        cfg.capacity_limit = '0;
        settings_used      = 0;
        src_idle_pct       = 19;
        dst_idle_pct       = 52;

        // Pool of keys for the random phases; keep both key extremes in it.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at the reset limit first.
        send_word(CMD_GET, 32'h8000_0000, 32'h1234_5678);   // miss on an empty table
        send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);   // hit, value ignored
        send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h0000_3039);   // overwrite a present key
        send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(CMD_GET, 32'h0000_0001, 32'h0000_0000);   // miss with entries present

        // Lower the limit below the occupancy: the next new key evicts twice.
        settle();
        write_limit(LIMIT_W'(3));
        send_word(CMD_PUT, 32'h0000_0011, 32'hA5A5_A5A5);
        send_word(CMD_PUT, 32'h0000_0022, 32'h5A5A_5A5A);   // evicts the newest, count one
        send_word(CMD_GET, 32'h0000_0011, 32'h0000_0000);   // gone now

        // Disable stores: every put is dropped, gets still find old entries.
        settle();
        write_limit(LIMIT_W'(0));
        send_word(CMD_PUT, 32'h0000_0044, 32'h0000_0001);
        send_word(CMD_PUT, 32'h8000_0000, 32'h0000_0002);
        send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);

        // Random phases. Draw most keys from a window of the pool a bit wider
        // than the limit, so hits, ties and evictions are all common.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_limit(PHASE_LIMIT[p]);
            if (p < 3)
            begin
                src_idle_pct = 19;
                dst_idle_pct = 52;
            end
            else if (p < 6)
            begin
                src_idle_pct = 52;
                dst_idle_pct = 19;
            end
            else
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            eff  = (PHASE_LIMIT[p] > CAPACITY) ? CAPACITY : int'(PHASE_LIMIT[p]);
            span = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
            base = $urandom_range(POOL_SIZE - 1);
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++)
            begin
                op = 1'($urandom_range(1));
                if ($urandom_range(9) == 0)
                    k = $urandom();
                else
                    k = key_pool[(base + $urandom_range(span - 1)) % POOL_SIZE];
                send_word(op, k, $urandom());
            end
        end

        // Drain, then let the checker look for words that never came.
        settle();
        drain_done = 1'b1;
        @(posedge clk);
        @(negedge clk);

        $display("Covered %0d response words over %0d capacity settings:",
                 served, settings_used);
        $display("%0d hits, %0d evicting puts.", hits, evictions);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/lfu_pkg.sv
rtl/lfu_ifs.sv
rtl/lfu_cmp_unit.sv
rtl/lfu_entry_store.sv
rtl/lfu_cache_table_unit.sv
bench/lfu_cache_checker.sv
bench/tb.sv
